/* src/mbw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw_pkg
// Shared types, codes and the try-order table for the maze backtracker walk.
// ----------------------------------------------------------------------------
package mbw_pkg;

    localparam int unsigned KIND_W  = 1;
    localparam int unsigned ORDER_W = 5;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned COORD_W = 5;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned DEPTH_W = 11;
    localparam int unsigned GRID_W  = 6;

    localparam logic [GRID_W-1:0]  GRID_RESET  = 6'd32;
    localparam logic [ORDER_W-1:0] ORDER_COUNT = 5'd24;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_START = 1'b0;
    localparam logic [KIND_W-1:0] KIND_STEP  = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_START = 2'd0,
        EV_CARVE = 2'd1,
        EV_BACK  = 2'd2,
        EV_EMPTY = 2'd3
    } t_event;

    typedef enum logic [DIR_W-1:0] {
        DIR_PCOL = 2'd0,
        DIR_PROW = 2'd1,
        DIR_NCOL = 2'd2,
        DIR_NROW = 2'd3
    } t_dir;

    // element [0] is tried first
    typedef logic [3:0][DIR_W-1:0] t_seq;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // step item taken: latch order, read stack top
        logic start;      // start item taken: reset stack, begin clear sweep
        logic clr_step;   // write one visited entry of the sweep
        logic res_start;  // stage start result
        logic res_empty;  // stage empty-stack result
        logic probe;      // read visited bit of the current candidate
        logic next_k;     // advance to the next direction
        logic carve;      // mark candidate, push it, stage carve result
        logic pop;        // pop top, stage backtrack result
        logic emit;       // move staged result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic depth_zero;
        logic clr_done;
        logic cand_ok;
        logic visited;
        logic last_try;
    } t_stat;

    function automatic t_seq mk_seq(input logic [DIR_W-1:0] a, input logic [DIR_W-1:0] b,
                                    input logic [DIR_W-1:0] c, input logic [DIR_W-1:0] d);
        t_seq s;
        s[0] = a;
        s[1] = b;
        s[2] = c;
        s[3] = d;
        return s;
    endfunction

    // lexicographic permutations of the four direction codes
    function automatic t_seq decode_order(input logic [ORDER_W-1:0] idx_in);
        logic [ORDER_W-1:0] idx;
        t_seq s;
        idx = (idx_in >= ORDER_COUNT) ? idx_in - ORDER_COUNT : idx_in;
        case (idx)
            5'd0:    s = mk_seq(2'd0, 2'd1, 2'd2, 2'd3);
            5'd1:    s = mk_seq(2'd0, 2'd1, 2'd3, 2'd2);
            5'd2:    s = mk_seq(2'd0, 2'd2, 2'd1, 2'd3);
            5'd3:    s = mk_seq(2'd0, 2'd2, 2'd3, 2'd1);
            5'd4:    s = mk_seq(2'd0, 2'd3, 2'd1, 2'd2);
            5'd5:    s = mk_seq(2'd0, 2'd3, 2'd2, 2'd1);
            5'd6:    s = mk_seq(2'd1, 2'd0, 2'd2, 2'd3);
            5'd7:    s = mk_seq(2'd1, 2'd0, 2'd3, 2'd2);
            5'd8:    s = mk_seq(2'd1, 2'd2, 2'd0, 2'd3);
            5'd9:    s = mk_seq(2'd1, 2'd2, 2'd3, 2'd0);
            5'd10:   s = mk_seq(2'd1, 2'd3, 2'd0, 2'd2);
            5'd11:   s = mk_seq(2'd1, 2'd3, 2'd2, 2'd0);
            5'd12:   s = mk_seq(2'd2, 2'd0, 2'd1, 2'd3);
            5'd13:   s = mk_seq(2'd2, 2'd0, 2'd3, 2'd1);
            5'd14:   s = mk_seq(2'd2, 2'd1, 2'd0, 2'd3);
            5'd15:   s = mk_seq(2'd2, 2'd1, 2'd3, 2'd0);
            5'd16:   s = mk_seq(2'd2, 2'd3, 2'd0, 2'd1);
            5'd17:   s = mk_seq(2'd2, 2'd3, 2'd1, 2'd0);
            5'd18:   s = mk_seq(2'd3, 2'd0, 2'd1, 2'd2);
            5'd19:   s = mk_seq(2'd3, 2'd0, 2'd2, 2'd1);
            5'd20:   s = mk_seq(2'd3, 2'd1, 2'd0, 2'd2);
            5'd21:   s = mk_seq(2'd3, 2'd1, 2'd2, 2'd0);
            5'd22:   s = mk_seq(2'd3, 2'd2, 2'd0, 2'd1);
            5'd23:   s = mk_seq(2'd3, 2'd2, 2'd1, 2'd0);
            default: s = mk_seq(2'd0, 2'd1, 2'd2, 2'd3);
        endcase
        return s;
    endfunction

endpackage

/* src/mbw_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw stream interfaces
// Valid/ready channels for walk items and walk events.
// ----------------------------------------------------------------------------
interface mbw_in_if
    import mbw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ORDER_W-1:0] order;

    modport source (output valid, output kind, output order, input ready);
    modport sink   (input valid, input kind, input order, output ready);
endinterface

interface mbw_out_if
    import mbw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DIR_W-1:0]   direction;
    logic [DEPTH_W-1:0] depth;

    modport source (output valid, output event_res, output row, output col,
                    output direction, output depth, input ready);
    modport sink   (input valid, input event_res, input row, input col,
                    input direction, input depth, output ready);
endinterface

/* src/mbw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw_datapath
// Visited map, cell stack, neighbor test and result registers.
// ----------------------------------------------------------------------------
module mbw_datapath
    import mbw_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [ORDER_W-1:0] i_order,
    input  logic               i_cfg_we,
    input  logic [GRID_W-1:0]  i_cfg_wdata,
    output logic [EVENT_W-1:0] o_event_res,
    output logic [COORD_W-1:0] o_row,
    output logic [COORD_W-1:0] o_col,
    output logic [DIR_W-1:0]   o_direction,
    output logic [DEPTH_W-1:0] o_depth
);

    localparam int unsigned CW     = $clog2(MAX_SIDE);
    localparam int unsigned VAW    = 2 * CW;
    localparam int unsigned VDEPTH = 1 << VAW;
    localparam int unsigned CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int unsigned SAW    = $clog2(CELLS);
    localparam int unsigned DW     = $clog2(CELLS + 1);
    localparam int unsigned SW     = ($clog2(MAX_SIDE + 1) > GRID_W) ?
                                     $clog2(MAX_SIDE + 1) : GRID_W;

    // visited map is addressed {row, col}; stack entries hold {row, col}
    logic                 vis_mem [VDEPTH];
    logic [VAW-1:0]       stk_mem [CELLS];

    logic [GRID_W-1:0]    r_grid;
    logic [DW-1:0]        r_depth;
    logic [DW-1:0]        n_depth;
    logic [VAW-1:0]       r_clr_addr;
    t_seq                 r_seq;
    logic [1:0]           r_k;
    logic                 r_vis_q;
    logic [VAW-1:0]       r_stk_q;

    t_event               r_st_ev;
    logic [CW-1:0]        r_st_row;
    logic [CW-1:0]        r_st_col;
    logic [DIR_W-1:0]     r_st_dir;
    logic [DW-1:0]        r_st_depth;

    t_event               r_o_ev;
    logic [CW-1:0]        r_o_row;
    logic [CW-1:0]        r_o_col;
    logic [DIR_W-1:0]     r_o_dir;
    logic [DW-1:0]        r_o_depth;

    logic [SW-1:0]        grid_x;
    logic [SW-1:0]        side;
    logic [CW-1:0]        tr;
    logic [CW-1:0]        tc;
    logic [SW-1:0]        tr_x;
    logic [SW-1:0]        tc_x;
    logic [CW-1:0]        nr;
    logic [CW-1:0]        nc;
    logic                 cand_ok;
    logic [DIR_W-1:0]     cur_dir;
    logic                 stk_full;

    // effective side: zero reads as one, clamp at MAX_SIDE
    always_comb begin
        grid_x = SW'(r_grid);
        if (grid_x == '0) begin
            side = SW'(1);
        end else if (grid_x > SW'(MAX_SIDE)) begin
            side = SW'(MAX_SIDE);
        end else begin
            side = grid_x;
        end
    end

    assign {tr, tc} = r_stk_q;
    assign tr_x     = SW'(tr);
    assign tc_x     = SW'(tc);
    assign cur_dir  = r_seq[r_k];
    assign stk_full = (r_depth >= DW'(CELLS));

    // neighbor of the stack top in the current direction, and its range test
    always_comb begin
        nr      = tr;
        nc      = tc;
        cand_ok = 1'b0;
        case (t_dir'(cur_dir))
            DIR_PCOL: begin
                nc      = tc + CW'(1);
                cand_ok = (tc_x + SW'(1) < side) && (tr_x < side);
            end
            DIR_PROW: begin
                nr      = tr + CW'(1);
                cand_ok = (tr_x + SW'(1) < side) && (tc_x < side);
            end
            DIR_NCOL: begin
                nc      = tc - CW'(1);
                cand_ok = (tc != '0) && (tc_x <= side) && (tr_x < side);
            end
            DIR_NROW: begin
                nr      = tr - CW'(1);
                cand_ok = (tr != '0) && (tr_x <= side) && (tc_x < side);
            end
            default: begin
                cand_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_depth = r_depth;
        if (i_cmd.start) begin
            n_depth = DW'(1);
        end else if (i_cmd.carve && !stk_full) begin
            n_depth = r_depth + DW'(1);
        end else if (i_cmd.pop) begin
            n_depth = r_depth - DW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid  <= GRID_RESET;
            r_depth <= '0;
        end else begin
            if (i_cfg_we) begin
                r_grid <= i_cfg_wdata;
            end
            r_depth <= n_depth;
        end
    end

    // walk registers and result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_seq <= decode_order(i_order);
            r_k   <= 2'd0;
        end else if (i_cmd.next_k) begin
            r_k <= r_k + 2'd1;
        end
        if (i_cmd.start) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + VAW'(1);
        end
        if (i_cmd.res_start) begin
            r_st_ev    <= EV_START;
            r_st_row   <= '0;
            r_st_col   <= '0;
            r_st_dir   <= '0;
            r_st_depth <= DW'(1);
        end else if (i_cmd.res_empty) begin
            r_st_ev    <= EV_EMPTY;
            r_st_row   <= '0;
            r_st_col   <= '0;
            r_st_dir   <= '0;
            r_st_depth <= '0;
        end else if (i_cmd.carve) begin
            r_st_ev    <= EV_CARVE;
            r_st_row   <= nr;
            r_st_col   <= nc;
            r_st_dir   <= cur_dir;
            r_st_depth <= n_depth;
        end else if (i_cmd.pop) begin
            r_st_ev    <= EV_BACK;
            r_st_row   <= tr;
            r_st_col   <= tc;
            r_st_dir   <= '0;
            r_st_depth <= n_depth;
        end
        if (i_cmd.emit) begin
            r_o_ev    <= r_st_ev;
            r_o_row   <= r_st_row;
            r_o_col   <= r_st_col;
            r_o_dir   <= r_st_dir;
            r_o_depth <= r_st_depth;
        end
    end

    // visited map: one port, sweep writes or carve writes or probe reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            vis_mem[r_clr_addr] <= (r_clr_addr == '0);
        end else if (i_cmd.carve) begin
            vis_mem[{nr, nc}] <= 1'b1;
        end else if (i_cmd.probe) begin
            r_vis_q <= vis_mem[{nr, nc}];
        end
    end

    // cell stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            stk_mem[SAW'(0)] <= '0;
        end else if (i_cmd.carve && !stk_full) begin
            stk_mem[r_depth[SAW-1:0]] <= {nr, nc};
        end else if (i_cmd.accept) begin
            r_stk_q <= stk_mem[n_depth[SAW-1:0] - SAW'(1)];
        end
    end

    assign o_stat.depth_zero = (r_depth == '0);
    assign o_stat.clr_done   = (r_clr_addr == VAW'(VDEPTH - 1));
    assign o_stat.cand_ok    = cand_ok;
    assign o_stat.visited    = r_vis_q;
    assign o_stat.last_try   = (r_k == 2'd3);

    assign o_event_res = r_o_ev;
    assign o_row       = COORD_W'(r_o_row);
    assign o_col       = COORD_W'(r_o_col);
    assign o_direction = r_o_dir;
    assign o_depth     = DEPTH_W'(r_o_depth);

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(CELLS))
        else $error("stack depth beyond cell count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.carve && !stk_full) |=> (r_depth == $past(r_depth) + DW'(1)))
        else $error("carve did not push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> (r_depth == $past(r_depth) - DW'(1)))
        else $error("pop did not shrink the stack");

endmodule

/* src/mbw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw_ctrl
// Sequencer for clear sweep, neighbor tries and result transfer.
// ----------------------------------------------------------------------------
module mbw_ctrl
    import mbw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_cmd              o_cmd,
    input  t_stat             i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_TRY,
        S_CHK,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_START) begin
                        cmd.start = 1'b1;
                        n_state   = S_CLEAR;
                    end else if (i_stat.depth_zero) begin
                        cmd.res_empty = 1'b1;
                        n_state       = S_OUT;
                    end else begin
                        cmd.accept = 1'b1;
                        n_state    = S_TRY;
                    end
                end
            end
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    cmd.res_start = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_TRY: begin
                if (i_stat.cand_ok) begin
                    cmd.probe = 1'b1;
                    n_state   = S_CHK;
                end else if (i_stat.last_try) begin
                    cmd.pop = 1'b1;
                    n_state = S_OUT;
                end else begin
                    cmd.next_k = 1'b1;
                end
            end
            S_CHK: begin
                if (!i_stat.visited) begin
                    cmd.carve = 1'b1;
                    n_state   = S_OUT;
                end else if (i_stat.last_try) begin
                    cmd.pop = 1'b1;
                    n_state = S_OUT;
                end else begin
                    cmd.next_k = 1'b1;
                    n_state    = S_TRY;
                end
            end
            S_OUT: begin
                // output register free, or being emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_start_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_kind == KIND_START) |=> (r_state == S_CLEAR))
        else $error("start did not enter the clear sweep");

    a_carve_unvisited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.carve |-> (r_state == S_CHK && !i_stat.visited && $past(i_stat.cand_ok)))
        else $error("carve into a visited or out-of-range cell");

    a_pop_after_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> i_stat.last_try)
        else $error("pop before all directions were tried");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote an untaken result");

endmodule

/* src/maze_backtracker_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_backtracker_walk
// Randomized depth-first maze carving, one walk event per item.
// ----------------------------------------------------------------------------
// Items enter on i_in (kind, order) and each gives exactly one event on o_out.
// kind start clears the visited map, marks cell (0,0) and makes it the only
// stack entry; kind step tries the four neighbors of the stack top in the
// order picked by 'order' and carves into the first free one, or pops.
// The grid side is set through i_cfg_we / i_cfg_wdata; the user must write
// it only while the block idles, as the block itself does not enforce this.
// A step takes the item and reads the stack top, then tries the directions
// in turn: one out of range is skipped, a neighbor in range is probed with
// one visited-map read, and the result then loads the output register. A
// step on an empty stack goes straight to the output register. A start
// sweeps the whole visited map, one entry per cycle.
// One item is in flight at a time; the next is taken as soon as the
// event moves into the output register, even while o_out still waits.
// Reset empties the stack and sets the side to 32; steps before the first
// start give the empty-stack event. A stalled receiver holds o_out and the
// block waits with the next event staged.
// ----------------------------------------------------------------------------
module maze_backtracker_walk
    import mbw_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbw_in_if.sink            i_in,
    mbw_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [GRID_W-1:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    mbw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_kind      (i_in.kind),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    mbw_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_order     (i_in.order),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_event_res (o_out.event_res),
        .o_row       (o_out.row),
        .o_col       (o_out.col),
        .o_direction (o_out.direction),
        .o_depth     (o_out.depth)
    );

endmodule

/* tb/maze_backtracker_walk_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_backtracker_walk_checker
// Watches the walk item and walk event channels and the grid register port.
// Keeps its own visited map, cell stack and grid side, works out the event
// each accepted item must give and compares every event transfer, field by
// field, against the oldest one still waiting.
// ----------------------------------------------------------------------------
module maze_backtracker_walk_checker
    import mbw_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbw_in_if                 i_item_mon,
    mbw_out_if                i_event_mon,
    input  logic              i_cfg_we,
    input  logic [GRID_W-1:0] i_cfg_wdata,
    output int                o_err_cnt,
    output int                o_open_cnt,
    output int                o_event_cnt
);

    localparam int unsigned CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int unsigned CELL_W = $clog2(CELLS);

    typedef struct packed {
        t_event             ev;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_dir               dir;
        logic [DEPTH_W-1:0] depth;
    } t_walk_event;

    bit                visited[CELLS];
    logic [CELL_W-1:0] cell_stack[CELLS];
    int unsigned       stack_depth;
    logic [GRID_W-1:0] grid_reg;
    t_walk_event       expected_events[$];
    int                err_cnt;
    int                event_cnt;

    // lexicographic rank -> try sequence, element [0] first
    function automatic logic [3:0][DIR_W-1:0] try_sequence(input logic [ORDER_W-1:0] order);
        int                      rank;
        int                      pick;
        int                      pool[4];
        int                      fact[4];
        logic [3:0][DIR_W-1:0]   seq;
        rank = (order >= ORDER_COUNT) ? int'(order) - int'(ORDER_COUNT) : int'(order);
        pool = '{0, 1, 2, 3};
        fact = '{6, 2, 1, 1};
        for (int k = 0; k < 4; k++) begin
            pick   = rank / fact[k];
            rank   = rank % fact[k];
            seq[k] = DIR_W'(pool[pick]);
            for (int j = pick; j < 3 - k; j++) begin
                pool[j] = pool[j + 1];
            end
        end
        return seq;
    endfunction

    function automatic t_walk_event walk_item(input logic [KIND_W-1:0] kind,
                                              input logic [ORDER_W-1:0] order);
        t_walk_event           res;
        logic [3:0][DIR_W-1:0] seq;
        int                    side;
        int                    top;
        int                    tr;
        int                    tc;
        int                    nr;
        int                    nc;
        t_dir                  d;
        res.ev    = EV_EMPTY;
        res.row   = '0;
        res.col   = '0;
        res.dir   = DIR_PCOL;
        res.depth = '0;

        if (kind == KIND_START) begin
            for (int i = 0; i < CELLS; i++) begin
                visited[i] = 1'b0;
            end
            visited[0]    = 1'b1;
            cell_stack[0] = '0;
            stack_depth   = 1;
            res.ev        = EV_START;
            res.depth     = DEPTH_W'(1);
            return res;
        end

        if (stack_depth == 0) begin
            return res;
        end

        side = (grid_reg == 0) ? 1 : (grid_reg > MAX_SIDE) ? MAX_SIDE : int'(grid_reg);
        top  = int'(cell_stack[stack_depth - 1]);
        tr   = top / MAX_SIDE;
        tc   = top % MAX_SIDE;
        seq  = try_sequence(order);

        for (int k = 0; k < 4; k++) begin
            d  = t_dir'(seq[k]);
            nr = tr + ((d == DIR_PROW) ? 1 : (d == DIR_NROW) ? -1 : 0);
            nc = tc + ((d == DIR_PCOL) ? 1 : (d == DIR_NCOL) ? -1 : 0);
            if (nr >= 0 && nc >= 0 && nr < side && nc < side
                    && !visited[nr * MAX_SIDE + nc]) begin
                visited[nr * MAX_SIDE + nc] = 1'b1;
                if (stack_depth < CELLS) begin
                    cell_stack[stack_depth] = CELL_W'(nr * MAX_SIDE + nc);
                    stack_depth++;
                end
                res.ev    = EV_CARVE;
                res.row   = nr[COORD_W-1:0];
                res.col   = nc[COORD_W-1:0];
                res.dir   = d;
                res.depth = DEPTH_W'(stack_depth);
                return res;
            end
        end

        // dead end: pop the top
        stack_depth--;
        res.ev    = EV_BACK;
        res.row   = tr[COORD_W-1:0];
        res.col   = tc[COORD_W-1:0];
        res.depth = DEPTH_W'(stack_depth);
        return res;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("event %0d field %s: expected %0d, actual %0d", event_cnt, field, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_walk_event got;
        t_walk_event want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                visited[i] = 1'b0;
            end
            stack_depth = 0;
            grid_reg    = GRID_RESET;
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                grid_reg = i_cfg_wdata;
            end
            if (i_item_mon.valid && i_item_mon.ready) begin
                expected_events.push_back(walk_item(i_item_mon.kind, i_item_mon.order));
            end
            if (i_event_mon.valid && i_event_mon.ready) begin
                got.ev    = t_event'(i_event_mon.event_res);
                got.row   = i_event_mon.row;
                got.col   = i_event_mon.col;
                got.dir   = t_dir'(i_event_mon.direction);
                got.depth = i_event_mon.depth;
                if (expected_events.size() == 0) begin
                    $error("event %0d arrived with no walk item waiting", event_cnt);
                    err_cnt++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_res", int'(want.ev), int'(got.ev));
                    check_field("row", int'(want.row), int'(got.row));
                    check_field("col", int'(want.col), int'(got.col));
                    check_field("direction", int'(want.dir), int'(got.dir));
                    check_field("depth", int'(want.depth), int'(got.depth));
                end
                event_cnt++;
            end
        end
        o_err_cnt   <= err_cnt;
        o_open_cnt  <= expected_events.size();
        o_event_cnt <= event_cnt;
    end

endmodule

/* tb/maze_backtracker_walk_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_backtracker_walk_tb
// Drives walk items and grid sizes into the maze walker and gives the verdict.
// A directed opener covers empty-stack steps, every direction, wrapped order
// indexes and odd grid sizes; then random walks, mostly complete ones on small
// grids, with resizes mid-walk, stray starts and a long output hold-off.
// ----------------------------------------------------------------------------
module maze_backtracker_walk_tb;
    import mbw_pkg::*;

    localparam int unsigned MAX_SIDE       = 32;
    localparam int          ITEM_GOAL      = 1050;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 20;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [GRID_W-1:0] cfg_wdata;
    int                gap_pct;
    int                stall_pct;
    logic              hold_go;
    int                err_cnt;
    int                open_cnt;
    int                event_cnt;
    int                sent_cnt;
    int                quiet_cycles;

    mbw_in_if  item_ch ();
    mbw_out_if event_ch ();

    maze_backtracker_walk #(
        .MAX_SIDE (MAX_SIDE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (item_ch),
        .o_out       (event_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    maze_backtracker_walk_checker #(
        .MAX_SIDE (MAX_SIDE)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_mon  (item_ch),
        .i_event_mon (event_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_err_cnt   (err_cnt),
        .o_open_cnt  (open_cnt),
        .o_event_cnt (event_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // event receiver; one long hold-off when asked, random stalls otherwise
    initial begin
        bit held;
        held = 1'b0;
        event_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !held) begin
                held = 1'b1;
                event_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                event_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready)
                || (event_ch.valid && event_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin gap_pct <= 0;  stall_pct <= 0;  end
            IDLE_SEND: begin gap_pct <= 56; stall_pct <= 0;  end
            IDLE_RECV: begin gap_pct <= 0;  stall_pct <= 56; end
            default:   begin gap_pct <= 32; stall_pct <= 32; end
        endcase
    endtask

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ORDER_W-1:0] order);
        while ($urandom_range(0, 99) < gap_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind  <= kind;
        item_ch.order <= order;
        do @(posedge i_clk); while (!item_ch.ready);
        sent_cnt++;
    endtask

    // every item gives one event, so the block idles once all are back
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (event_cnt != sent_cnt || open_cnt != 0) @(posedge i_clk);
    endtask

    task automatic write_grid(input logic [GRID_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // random steps; with noise on, a stray start now and then breaks the walk
    task automatic walk_steps(input int n, input bit noisy);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 49) == 0) begin
                send_item(KIND_START, ORDER_W'($urandom_range(0, 31)));
            end else begin
                send_item(KIND_STEP, ORDER_W'($urandom_range(0, 31)));
            end
        end
    endtask

    // steps to finish a walk; large sides only get a partial walk
    function automatic int full_walk_steps(input logic [GRID_W-1:0] grid);
        int side;
        side = (grid == 0) ? 1 : (grid > MAX_SIDE) ? MAX_SIDE : int'(grid);
        return (side > 8) ? 40 : 2 * side * side - 1;
    endfunction

    initial begin
        logic [GRID_W-1:0] grid;
        int                n_steps;
        int                half;
        int                walk_no;
        i_rst_n       <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.kind  <= KIND_START;
        item_ch.order <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        hold_go       <= 1'b0;
        gap_pct       <= 0;
        stall_pct     <= 0;
        sent_cnt       = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // steps on the empty stack after reset
        send_item(KIND_STEP, 5'd0);
        send_item(KIND_STEP, 5'd31);
        send_item(KIND_START, 5'd31);
        // all four directions, a dead end, then wrapped indexes
        send_item(KIND_STEP, 5'd23);
        send_item(KIND_STEP, 5'd0);
        send_item(KIND_STEP, 5'd12);
        send_item(KIND_STEP, 5'd18);
        send_item(KIND_STEP, 5'd16);
        send_item(KIND_STEP, 5'd5);
        send_item(KIND_STEP, 5'd24);
        send_item(KIND_STEP, 5'd31);
        // side of zero means one cell: each step now pops a cell off the stack
        wait_idle();
        write_grid(6'd0);
        send_item(KIND_STEP, 5'd9);
        send_item(KIND_STEP, 5'd2);
        send_item(KIND_STEP, 5'd30);
        wait_idle();
        write_grid(6'd63);
        send_item(KIND_STEP, 5'd17);
        wait_idle();
        write_grid(6'd1);
        send_item(KIND_START, 5'd0);
        send_item(KIND_STEP, 5'd11);
        send_item(KIND_STEP, 5'd20);

        // full side: run along row 0 and down the last column
        wait_idle();
        write_grid(6'd32);
        send_item(KIND_START, 5'd0);
        for (int i = 0; i < 64; i++) begin
            send_item(KIND_STEP, ORDER_W'($urandom_range(0, 1)));
        end
        // receiver holds off while items keep coming
        hold_go <= 1'b1;
        walk_steps(40, 1'b0);
        // shrink under a deep stack, then unwind it
        wait_idle();
        hold_go <= 1'b0;
        write_grid(6'd4);
        walk_steps(130, 1'b0);

        walk_no = 0;
        while (sent_cnt < ITEM_GOAL) begin
            wait_idle();
            set_idling(t_idle_mode'(walk_no % 4));
            if ($urandom_range(0, 9) == 0) begin
                grid = $urandom_range(0, 1) ? 6'd0 : GRID_W'($urandom_range(33, 63));
            end else begin
                grid = GRID_W'($urandom_range(1, 6));
            end
            write_grid(grid);
            n_steps = full_walk_steps(grid) + $urandom_range(0, 2);
            send_item(KIND_START, ORDER_W'($urandom_range(0, 31)));
            half = ($urandom_range(0, 5) == 0) ? n_steps / 2 : 0;
            walk_steps(half, 1'b1);
            if (half != 0) begin
                wait_idle();
                grid = GRID_W'($urandom_range(1, 6));
                write_grid(grid);
                n_steps += full_walk_steps(grid);
            end
            walk_steps(n_steps - half, 1'b1);
            walk_no++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && open_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* maze_backtracker_walk.f */
src/mbw_pkg.sv
src/mbw_stream_if.sv
src/mbw_datapath.sv
src/mbw_ctrl.sv
src/maze_backtracker_walk.sv
tb/maze_backtracker_walk_checker.sv
tb/maze_backtracker_walk_tb.sv
